>>> hw/rtl/pcfc_pkg.sv
`default_nettype none
package pcfc_pkg;

  localparam int CHAN_W = 32;
  localparam int NUM_LANES = 4;
  localparam int PIPE_DEPTH = 4;

  localparam logic [2:0] FMT_U8     = 3'd0;
  localparam logic [2:0] FMT_U16    = 3'd1;
  localparam logic [2:0] FMT_U32    = 3'd2;
  localparam logic [2:0] FMT_HALF   = 3'd3;
  localparam logic [2:0] FMT_SINGLE = 3'd4;

  localparam logic [1:0] CFG_SRC_TYPE  = 2'd0;
  localparam logic [1:0] CFG_DST_TYPE  = 2'd1;
  localparam logic [1:0] CFG_SRC_COUNT = 2'd2;
  localparam logic [1:0] CFG_DST_COUNT = 2'd3;

  localparam logic [CHAN_W-1:0] ONE_SINGLE = 32'h3F80_0000;
  localparam logic [CHAN_W-1:0] ONE_HALF   = 32'h0000_3C00;

  typedef enum logic [1:0] {
    LANE_ZERO = 2'd0,
    LANE_RAW  = 2'd1,
    LANE_FILL = 2'd2,
    LANE_CONV = 2'd3
  } lane_mode_t;

  typedef struct packed {
    logic       valid;
    lane_mode_t mode;
  } lane_ctl_t;

  typedef struct packed {
    logic [31:0] in_chan0;
    logic [31:0] in_chan1;
    logic [31:0] in_chan2;
    logic [31:0] in_chan3;
    logic        in_last;
  } pixel_in_t;

  typedef struct packed {
    logic [31:0] out_chan0;
    logic [31:0] out_chan1;
    logic [31:0] out_chan2;
    logic [31:0] out_chan3;
    logic        out_last;
  } pixel_out_t;

  function automatic logic [CHAN_W-1:0] fmt_mask(input logic [2:0] t);
    logic [CHAN_W-1:0] m;
    case (t)
      FMT_U8:   m = 32'h0000_00FF;
      FMT_U16:  m = 32'h0000_FFFF;
      FMT_HALF: m = 32'h0000_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [CHAN_W-1:0] fmt_max(input logic [2:0] t);
    logic [CHAN_W-1:0] m;
    case (t)
      FMT_U8:  m = 32'h0000_00FF;
      FMT_U16: m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pixel_channel_format_converter.sv
// A pixel accepted while start is high and busy is low passes the four-stage lane
// pipeline and then shows on result, strobe high for exactly one cycle.
// Throughput: one pixel per cycle while busy is low, through the lane pipeline.
// Reset clears the format registers to u8/u8, counts to four, and drops every
// pixel in flight; busy stays high for one cycle after reset.
`default_nettype none
module pixel_channel_format_converter #(
  parameter int MAX_CHANNELS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  pcfc_pkg::pixel_in_t  pixel,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [2:0]           cfg_data,
  output logic                 strobe,
  output pcfc_pkg::pixel_out_t result
);
  import pcfc_pkg::*;

  localparam logic [2:0] MAX_CNT = 3'(MAX_CHANNELS);

  logic [2:0] src_type;
  logic [2:0] dst_type;
  logic [2:0] src_count;
  logic [2:0] dst_count;
  logic [2:0] sc;
  logic [2:0] dc;
  logic       fmt_ok;
  logic       same;
  logic       accept;

  logic [31:0] raw_in [NUM_LANES];
  logic [31:0] chan_out [NUM_LANES];
  logic        lane_valid [NUM_LANES];
  logic        last_pipe [PIPE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      src_type  <= FMT_U8;
      dst_type  <= FMT_U8;
      src_count <= 3'd4;
      dst_count <= 3'd4;
      busy      <= 1'b1;
    end else begin
      busy <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SRC_TYPE:  src_type  <= cfg_data;
          CFG_DST_TYPE:  dst_type  <= cfg_data;
          CFG_SRC_COUNT: src_count <= cfg_data;
          CFG_DST_COUNT: dst_count <= cfg_data;
          default:       src_type  <= src_type;
        endcase
      end
    end
  end

  assign sc     = (src_count == 3'd0) ? 3'd1 : ((src_count > MAX_CNT) ? MAX_CNT : src_count);
  assign dc     = (dst_count == 3'd0) ? 3'd1 : ((dst_count > MAX_CNT) ? MAX_CNT : dst_count);
  assign fmt_ok = (src_type <= FMT_SINGLE) && (dst_type <= FMT_SINGLE);
  assign same   = (src_type == dst_type) && (sc == dc);
  assign accept = start && !busy;

  assign raw_in[0] = pixel.in_chan0;
  assign raw_in[1] = pixel.in_chan1;
  assign raw_in[2] = pixel.in_chan2;
  assign raw_in[3] = pixel.in_chan3;

  for (genvar ch = 0; ch < NUM_LANES; ch++) begin : g_lane
    if (ch < MAX_CHANNELS) begin : g_on
      lane_ctl_t   ctl_in;
      lane_ctl_t   ctl_mid;
      lane_ctl_t   ctl_out;
      logic [31:0] raw_mid;
      logic [31:0] bits_mid;

      always_comb begin
        ctl_in.valid = accept;
        if (!fmt_ok || (3'(ch) >= dc)) begin
          ctl_in.mode = LANE_ZERO;
        end else if (same) begin
          ctl_in.mode = LANE_RAW;
        end else if (3'(ch) < sc) begin
          ctl_in.mode = ((src_type == dst_type) && (src_type >= FMT_HALF)) ?
                        LANE_RAW : LANE_CONV;
        end else begin
          ctl_in.mode = LANE_FILL;
        end
      end

      pcfc_to_single u_to_single (
        .clk      (clk),
        .rst      (rst),
        .in_ctl   (ctl_in),
        .in_raw   (raw_in[ch]),
        .src_type (src_type),
        .out_ctl  (ctl_mid),
        .out_raw  (raw_mid),
        .out_bits (bits_mid)
      );

      pcfc_from_single u_from_single (
        .clk      (clk),
        .rst      (rst),
        .in_ctl   (ctl_mid),
        .in_raw   (raw_mid),
        .in_bits  (bits_mid),
        .dst_type (dst_type),
        .out_ctl  (ctl_out),
        .out_chan (chan_out[ch])
      );

      assign lane_valid[ch] = ctl_out.valid;
    end else begin : g_off
      assign chan_out[ch]   = '0;
      assign lane_valid[ch] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    last_pipe[0] <= pixel.in_last;
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      last_pipe[i] <= last_pipe[i-1];
    end
  end

  assign strobe           = lane_valid[0];
  assign result.out_chan0 = chan_out[0];
  assign result.out_chan1 = chan_out[1];
  assign result.out_chan2 = chan_out[2];
  assign result.out_chan3 = chan_out[3];
  assign result.out_last  = last_pipe[PIPE_DEPTH-1];

  a_strobe_has_beat: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(accept, PIPE_DEPTH))
    else $error("result strobe without an accepted beat");

  a_beat_gives_strobe: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##PIPE_DEPTH strobe)
    else $error("accepted beat produced no result");

  a_last_follows: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.out_last == $past(pixel.in_last, PIPE_DEPTH)))
    else $error("last marker out of step with its beat");

endmodule
`default_nettype wire

>>> hw/rtl/pcfc_to_single.sv
`default_nettype none
module pcfc_to_single (
  input  logic                clk,
  input  logic                rst,
  input  pcfc_pkg::lane_ctl_t in_ctl,
  input  logic [31:0]         in_raw,
  input  logic [2:0]          src_type,
  output pcfc_pkg::lane_ctl_t out_ctl,
  output logic [31:0]         out_raw,
  output logic [31:0]         out_bits
);
  import pcfc_pkg::*;

  logic [31:0] x;
  logic [63:0] wide;
  logic [7:0]  base;
  logic        need_round;
  logic        sgn;
  logic [31:0] direct;
  logic        sticky;
  logic [4:0]  lz;
  logic [63:0] aligned;

  lane_ctl_t   ctl1;
  logic [31:0] raw1;
  logic        rnd1;
  logic        sgn1;
  logic [7:0]  exp1;
  logic [31:0] w1;
  logic        sticky1;
  logic [31:0] direct1;

  logic [22:0] mant;
  logic        up;
  logic [31:0] bits_next;

  always_comb begin
    x          = in_raw & fmt_mask(src_type);
    wide       = '0;
    base       = 8'd126;
    need_round = 1'b0;
    sgn        = 1'b0;
    direct     = '0;
    sticky     = 1'b0;
    case (src_type)
      FMT_U8: begin
        if (x[7:0] == 8'hFF) begin
          direct = ONE_SINGLE;
        end else if (x[7:0] != 8'h00) begin
          wide       = {8{x[7:0]}};
          need_round = 1'b1;
          sticky     = 1'b1;
        end
      end
      FMT_U16: begin
        if (x[15:0] == 16'hFFFF) begin
          direct = ONE_SINGLE;
        end else if (x[15:0] != 16'h0000) begin
          wide       = {4{x[15:0]}};
          need_round = 1'b1;
          sticky     = 1'b1;
        end
      end
      FMT_U32: begin
        if (x != 32'd0) begin
          wide       = {x, 32'd0};
          need_round = 1'b1;
        end
      end
      FMT_HALF: begin
        sgn = x[15];
        if (x[14:10] == 5'h1F) begin
          if (x[9:0] == 10'd0) begin
            direct = {x[15], 31'h7F80_0000};
          end else begin
            direct = {x[15], 31'h7FC0_0000} | {9'd0, x[9:0], 13'd0};
          end
        end else if (x[14:10] != 5'd0) begin
          direct = {x[15], 3'(8'd0) + 8'({3'd0, x[14:10]} + 8'd112), x[9:0], 13'd0};
        end else if (x[9:0] == 10'd0) begin
          direct = {x[15], 31'd0};
        end else begin
          wide       = {x[9:0], 54'd0};
          base       = 8'd112;
          need_round = 1'b1;
        end
      end
      FMT_SINGLE: direct = x;
      default:    direct = '0;
    endcase
  end

  always_comb begin
    lz = '0;
    for (int i = 0; i < 32; i++) begin
      if (wide[32+i]) lz = 5'(31 - i);
    end
  end

  assign aligned = wide << lz;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else begin
      ctl1 <= in_ctl;
    end
    raw1    <= x;
    rnd1    <= need_round;
    sgn1    <= sgn;
    exp1    <= base - {3'd0, lz};
    w1      <= aligned[63:32];
    sticky1 <= sticky;
    direct1 <= direct;
  end

  assign mant = w1[30:8];
  assign up   = w1[7] & ((|w1[6:0]) | sticky1 | mant[0]);
  assign bits_next = rnd1 ? ({sgn1, exp1, mant} + {31'd0, up}) : direct1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= ctl1;
    end
    out_raw  <= raw1;
    out_bits <= bits_next;
  end

endmodule
`default_nettype wire

>>> hw/rtl/pcfc_from_single.sv
`default_nettype none
module pcfc_from_single (
  input  logic                clk,
  input  logic                rst,
  input  pcfc_pkg::lane_ctl_t in_ctl,
  input  logic [31:0]         in_raw,
  input  logic [31:0]         in_bits,
  input  logic [2:0]          dst_type,
  output pcfc_pkg::lane_ctl_t out_ctl,
  output logic [31:0]         out_chan
);
  import pcfc_pkg::*;

  logic        s;
  logic [7:0]  e;
  logic [22:0] m;
  logic [23:0] full;
  logic [4:0]  hsh;
  logic [23:0] hm_sub;
  logic [23:0] rem_sub;
  logic [23:0] half_pt;
  logic [14:0] hb;
  logic        hup;
  logic [55:0] p;
  logic        izero;
  logic        imax;

  lane_ctl_t   ctl3;
  logic [31:0] raw3;
  logic [31:0] bits3;
  logic        hs3;
  logic [14:0] hb3;
  logic        hup3;
  logic [55:0] p3;
  logic [7:0]  sh3;
  logic        izero3;
  logic        imax3;

  logic        rup;
  logic [56:0] pr;
  logic [56:0] shifted;
  logic [31:0] ival;
  logic [31:0] conv;
  logic [31:0] fill;
  logic [31:0] chan_next;

  assign s    = in_bits[31];
  assign e    = in_bits[30:23];
  assign m    = in_bits[22:0];
  assign full = {1'b1, m};

  always_comb begin
    hb      = '0;
    hup     = 1'b0;
    hsh     = 5'(8'd126 - e);
    hm_sub  = full >> hsh;
    rem_sub = full & ((24'd1 << hsh) - 24'd1);
    half_pt = 24'd1 << (hsh - 5'd1);
    if (e == 8'hFF) begin
      hb = (m != 23'd0) ? (15'h7E00 | {5'd0, m[22:13]}) : 15'h7C00;
    end else if (e >= 8'd143) begin
      hb = 15'h7C00;
    end else if (e >= 8'd113) begin
      hb  = {5'(e - 8'd112), m[22:13]};
      hup = (m[12:0] > 13'h1000) || ((m[12:0] == 13'h1000) && m[13]);
    end else if (e >= 8'd102) begin
      hb  = hm_sub[14:0];
      hup = (rem_sub > half_pt) || ((rem_sub == half_pt) && hm_sub[0]);
    end
  end

  always_comb begin
    case (dst_type)
      FMT_U8:  p = ({32'd0, full} << 8) - {32'd0, full};
      FMT_U16: p = ({32'd0, full} << 16) - {32'd0, full};
      default: p = ({32'd0, full} << 32) - {32'd0, full};
    endcase
    izero = 1'b0;
    imax  = 1'b0;
    if (((e == 8'hFF) && (m != 23'd0)) || s) begin
      izero = 1'b1;
    end else if (e >= 8'd127) begin
      imax = 1'b1;
    end else if (e == 8'd0) begin
      izero = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3 <= '0;
    end else begin
      ctl3 <= in_ctl;
    end
    raw3   <= in_raw;
    bits3  <= in_bits;
    hs3    <= s;
    hb3    <= hb;
    hup3   <= hup;
    p3     <= p;
    sh3    <= 8'd150 - e;
    izero3 <= izero;
    imax3  <= imax;
  end

  always_comb begin
    rup = 1'b0;
    pr  = {1'b0, p3};
    if (p3[55]) begin
      rup = p3[2] & (p3[3] | p3[1] | p3[0]);
      pr  = {({1'b0, p3[55:3]} + 54'(rup)), 3'd0};
    end else if (p3[54]) begin
      rup = p3[1] & (p3[2] | p3[0]);
      pr  = {({1'b0, p3[55:2]} + 55'(rup)), 2'd0};
    end
    shifted = pr >> sh3;
    ival    = izero3 ? 32'd0 : (imax3 ? fmt_max(dst_type) : shifted[31:0]);
  end

  always_comb begin
    case (dst_type)
      FMT_SINGLE: conv = bits3;
      FMT_HALF:   conv = {16'd0, hs3, hb3 + {14'd0, hup3}};
      FMT_U8, FMT_U16, FMT_U32: conv = ival;
      default:    conv = '0;
    endcase
    case (dst_type)
      FMT_HALF:   fill = ONE_HALF;
      FMT_SINGLE: fill = ONE_SINGLE;
      default:    fill = fmt_max(dst_type);
    endcase
    case (ctl3.mode)
      LANE_RAW:  chan_next = raw3;
      LANE_FILL: chan_next = fill;
      LANE_CONV: chan_next = conv;
      default:   chan_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= ctl3;
    end
    out_chan <= chan_next;
  end

endmodule
`default_nettype wire

>>> tb/pixel_channel_format_converter_checker.sv
module pixel_channel_format_converter_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  pcfc_pkg::pixel_in_t  pixel,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [2:0]           cfg_data,
  input  logic                 strobe,
  input  pcfc_pkg::pixel_out_t result,
  output int                   errors,
  output int                   pending
);
  import pcfc_pkg::*;

  logic [2:0] src_fmt, dst_fmt, src_cnt, dst_cnt;
  pixel_out_t expected_pixels[$];

  function automatic logic [31:0] raw_mask(input logic [2:0] t);
    case (t)
      FMT_U8:             return 32'h0000_00FF;
      FMT_U16, FMT_HALF:  return 32'h0000_FFFF;
      default:            return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic longint unorm_max(input logic [2:0] t);
    case (t)
      FMT_U8:  return 64'hFF;
      FMT_U16: return 64'hFFFF;
      default: return 64'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] half_bits_to_single(input logic [15:0] h);
    logic [31:0] s, e, m, r;
    int p;
    s = {h[15], 31'd0};
    e = 32'(h[14:10]);
    m = 32'(h[9:0]);
    if (e == 0) begin
      if (m == 0) return s;
      p = 0;
      for (int i = 0; i < 10; i++) if (m[i]) p = i;
      r = m << (23 - p);
      return s | (32'(p + 103) << 23) | (r & 32'h007F_FFFF);
    end
    if (e == 31) begin
      if (m == 0) return s | 32'h7F80_0000;
      return s | 32'h7FC0_0000 | (m << 13);
    end
    return s | ((e + 112) << 23) | (m << 13);
  endfunction

  function automatic logic [31:0] single_bits_to_half(input logic [31:0] x);
    logic [31:0] s, e, m, hm, rem, up, full, sh, hlf;
    s = (x >> 16) & 32'h8000;
    e = (x >> 23) & 32'hFF;
    m = x & 32'h7F_FFFF;
    if (e == 255) begin
      if (m != 0) return s | 32'h7E00 | (m >> 13);
      return s | 32'h7C00;
    end
    if (e >= 143) return s | 32'h7C00;
    if (e >= 113) begin
      hm = m >> 13;
      rem = m & 32'h1FFF;
      up = (rem > 32'h1000 || (rem == 32'h1000 && hm[0])) ? 1 : 0;
      return s | ((((e - 112) << 10) | hm) + up);
    end
    if (e < 102) return s;
    full = m | 32'h80_0000;
    sh = 126 - e;
    hm = full >> sh;
    rem = full & ((32'd1 << sh) - 1);
    hlf = 32'd1 << (sh - 1);
    up = (rem > hlf || (rem == hlf && hm[0])) ? 1 : 0;
    return s | (hm + up);
  endfunction

  function automatic real single_bits_to_real(input logic [31:0] b);
    logic [10:0] de;
    if (b[30:23] == 8'hFF) return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'd0});
    if (b[30:23] == 0)
      return (b[31] ? -1.0 : 1.0) * real'(b[22:0]) * $bitstoreal({1'b0, 11'd874, 52'd0});
    de = 11'(b[30:23]) + 11'd896;
    return $bitstoreal({b[31], de, b[22:0], 29'd0});
  endfunction

  // nonzero values here always land in the normal single range
  function automatic logic [31:0] real_to_single_bits(input real x);
    logic [63:0] b;
    logic [52:0] full;
    logic [28:0] rem;
    logic [24:0] hm;
    int e;
    if (x == 0.0) return 32'd0;
    b = $realtobits(x);
    e = int'(b[62:52]) - 1023 + 127;
    full = {1'b1, b[51:0]};
    hm = 25'(full >> 29);
    rem = full[28:0];
    if (rem > 29'h1000_0000 || (rem == 29'h1000_0000 && hm[0])) hm = hm + 1;
    if (hm[24]) begin
      hm = hm >> 1;
      e = e + 1;
    end
    return {b[63], 8'(e), hm[22:0]};
  endfunction

  function automatic longint truncate_down(input real p);
    longint r;
    r = longint'(p);
    if (real'(r) > p) r = r - 1;
    return r;
  endfunction

  function automatic logic [31:0] convert_lane(input logic [2:0] st, input logic [2:0] dt,
                                               input logic [31:0] raw_in);
    logic [31:0] raw, fb, qb;
    real v, c, rs, ms;
    longint r, mx;
    raw = raw_in & raw_mask(st);
    if (st >= FMT_HALF) begin
      fb = (st == FMT_HALF) ? half_bits_to_single(raw[15:0]) : raw;
      if (dt >= FMT_HALF) begin
        if (st == dt) return raw;
        return (dt == FMT_SINGLE) ? fb : single_bits_to_half(fb);
      end
      if (fb[30:23] == 8'hFF && fb[22:0] != 0) return 32'd0;
      v = single_bits_to_real(fb);
      c = v < 0.0 ? 0.0 : (v > 1.0 ? 1.0 : v);
      return 32'(truncate_down(c * real'(unorm_max(dt))));
    end
    mx = unorm_max(st);
    rs = single_bits_to_real(real_to_single_bits(real'(64'(raw))));
    ms = single_bits_to_real(real_to_single_bits(real'(mx)));
    qb = real_to_single_bits(rs / ms);
    if (dt >= FMT_HALF) return (dt == FMT_SINGLE) ? qb : single_bits_to_half(qb);
    v = single_bits_to_real(qb) * real'(unorm_max(dt));
    if (v < 0.0) v = 0.0;
    r = truncate_down(v);
    if (r > unorm_max(dt)) r = unorm_max(dt);
    return 32'(r);
  endfunction

  function automatic logic [2:0] clamp_count(input logic [2:0] c);
    if (c < 1) return 3'd1;
    if (c > 4) return 3'd4;
    return c;
  endfunction

  function automatic pixel_out_t convert_pixel(input pixel_in_t px);
    logic [31:0] raw[4];
    logic [31:0] lane[4];
    logic [2:0] sc, dc;
    logic ok, same;
    pixel_out_t o;
    raw = '{px.in_chan0, px.in_chan1, px.in_chan2, px.in_chan3};
    sc = clamp_count(src_cnt);
    dc = clamp_count(dst_cnt);
    ok = src_fmt <= FMT_SINGLE && dst_fmt <= FMT_SINGLE;
    same = src_fmt == dst_fmt && sc == dc;
    for (int ch = 0; ch < 4; ch++) begin
      lane[ch] = '0;
      if (ok && ch < dc) begin
        if (same) lane[ch] = raw[ch] & raw_mask(src_fmt);
        else if (ch < sc) lane[ch] = convert_lane(src_fmt, dst_fmt, raw[ch]);
        else if (dst_fmt == FMT_HALF) lane[ch] = ONE_HALF;
        else if (dst_fmt == FMT_SINGLE) lane[ch] = ONE_SINGLE;
        else lane[ch] = 32'(unorm_max(dst_fmt));
      end
    end
    o.out_chan0 = lane[0];
    o.out_chan1 = lane[1];
    o.out_chan2 = lane[2];
    o.out_chan3 = lane[3];
    o.out_last = px.in_last;
    return o;
  endfunction

  assign pending = expected_pixels.size();

  always @(posedge clk) begin
    pixel_out_t e;
    if (rst) begin
      src_fmt <= FMT_U8;
      dst_fmt <= FMT_U8;
      src_cnt <= 3'd4;
      dst_cnt <= 3'd4;
      expected_pixels.delete();
      errors <= 0;
    end else begin
      if (start && !busy)
        expected_pixels.insert(expected_pixels.size(), convert_pixel(pixel));
      if (cfg_we) begin
        case (cfg_index)
          CFG_SRC_TYPE:  src_fmt <= cfg_data;
          CFG_DST_TYPE:  dst_fmt <= cfg_data;
          CFG_SRC_COUNT: src_cnt <= cfg_data;
          CFG_DST_COUNT: dst_cnt <= cfg_data;
          default: ;
        endcase
      end
      if (strobe) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result beat");
          errors <= errors + 1;
        end else begin
          e = expected_pixels.pop_front();
          if (result !== e) begin
            if (result.out_chan0 !== e.out_chan0)
              $error("out_chan0 expected %h actual %h", e.out_chan0, result.out_chan0);
            if (result.out_chan1 !== e.out_chan1)
              $error("out_chan1 expected %h actual %h", e.out_chan1, result.out_chan1);
            if (result.out_chan2 !== e.out_chan2)
              $error("out_chan2 expected %h actual %h", e.out_chan2, result.out_chan2);
            if (result.out_chan3 !== e.out_chan3)
              $error("out_chan3 expected %h actual %h", e.out_chan3, result.out_chan3);
            if (result.out_last !== e.out_last)
              $error("out_last expected %b actual %b", e.out_last, result.out_last);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

>>> tb/pixel_channel_format_converter_tb.sv
module pixel_channel_format_converter_tb;
  import pcfc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  pixel_in_t pixel = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_SRC_TYPE;
  logic [2:0] cfg_data = '0;
  logic strobe;
  pixel_out_t result;
  int errors, pending;
  int cycles = 0;

  logic [31:0] corner_values[16] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_7C00, 32'h0000_7E01,
    32'h0000_FC00, 32'h0000_3C00, 32'h0000_0001, 32'h7FC0_0001,
    32'h7F80_0001, 32'h3F80_0000, 32'h3F7F_FFFF, 32'hBF80_0000,
    32'h0000_0001, 32'h477F_F000, 32'h0000_80FF, 32'h8000_7FFF
  };

  pixel_channel_format_converter u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel(pixel),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .result(result)
  );

  pixel_channel_format_converter_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel(pixel),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .result(result), .errors(errors), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [31:0] channel_value();
    if ($urandom_range(0, 9) < 4) return $urandom();
    return corner_values[$urandom_range(0, 15)];
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [2:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(input pixel_in_t px, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pixel <= px;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  initial begin
    pixel_in_t px;
    logic [2:0] st, dt, sc, dc;
    int idle_mode;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < 30; p++) begin
      if (p < 25) begin
        st = 3'(p / 5);
        dt = 3'(p % 5);
        if (p < 5) begin
          sc = 3'd4;
          dc = 3'd4;
        end else begin
          sc = 3'($urandom_range(1, 4));
          dc = ($urandom_range(0, 2) == 0) ? sc : 3'($urandom_range(1, 4));
        end
      end else begin
        st = 3'($urandom_range(0, 7));
        dt = 3'($urandom_range(0, 7));
        sc = 3'($urandom_range(0, 7));
        dc = 3'($urandom_range(0, 7));
      end
      if (p > 0) begin
        write_reg(CFG_SRC_TYPE, st);
        write_reg(CFG_DST_TYPE, dt);
        write_reg(CFG_SRC_COUNT, sc);
        write_reg(CFG_DST_COUNT, dc);
      end
      idle_mode = $urandom_range(0, 2);
      for (int i = 0; i < 14; i++) begin
        if (i < 4) begin
          px.in_chan0 = corner_values[(i * 4 + p) % 16];
          px.in_chan1 = corner_values[(i * 4 + 1 + p) % 16];
          px.in_chan2 = corner_values[(i * 4 + 2 + p) % 16];
          px.in_chan3 = corner_values[(i * 4 + 3 + p) % 16];
        end else begin
          px.in_chan0 = channel_value();
          px.in_chan1 = channel_value();
          px.in_chan2 = channel_value();
          px.in_chan3 = channel_value();
        end
        px.in_last = 1'($urandom_range(0, 1));
        send_pixel(px, idle_mode == 0 ? 0 : $urandom_range(0, 5));
      end
      drain();
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> sim.f
hw/rtl/pcfc_pkg.sv
hw/rtl/pcfc_to_single.sv
hw/rtl/pcfc_from_single.sv
hw/rtl/pixel_channel_format_converter.sv
tb/pixel_channel_format_converter_checker.sv
tb/pixel_channel_format_converter_tb.sv
